>>> hdl/apsk16_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the sine table builder for the 16-point APSK modulator.
// No dependencies; every other file of the block imports this package.
package apsk16_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int MAX_BURST       = 64;
  localparam int PHASE_W         = 16;
  localparam int MAP_W           = 64;
  localparam int SPS_W           = 7;
  localparam int CNT_W           = $clog2(MAX_BURST + 1);
  localparam int QTR_N           = 1 << (SINE_TABLE_BITS - 2);
  localparam int POS_W           = SINE_TABLE_BITS - 1;

  localparam logic [MAP_W-1:0]   MAP_RESET  = 64'd2526762313582584592;
  localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_W'(42);
  localparam logic [SPS_W-1:0]   SPS_RESET  = SPS_W'(MAX_BURST);

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint CA1     = 64'sd1686629713;
  localparam longint CA3     = 64'sd693598668;
  localparam longint CA5     = 64'sd85569306;
  localparam longint CA7     = 64'sd5026995;
  localparam longint CA9     = 64'sd172272;
  localparam longint FULL    = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;

  typedef enum logic [1:0] {
    CFG_SYMBOL_MAP         = 2'd0,
    CFG_PHASE_STEP         = 2'd1,
    CFG_SAMPLES_PER_SYMBOL = 2'd2
  } cfg_idx_e;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SAMPLE_WIDTH-2:0]        mag_t;
  typedef mag_t                           mag_tab_t [0:QTR_N];

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Q30 product with the magnitude rounded half up and the sign kept.
  function automatic logic signed [63:0] q30_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic        neg;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] m;
    neg = a[63] ^ b[63];
    ma  = a[63] ? 64'(-a) : 64'(a);
    mb  = b[63] ? 64'(-b) : 64'(b);
    m   = (ma * mb + (64'd1 << 29)) >> 30;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // Quarter-wave magnitude table, evaluated at elaboration only.
  function automatic mag_tab_t build_mag_tab(input logic half);
    mag_tab_t             tab;
    logic signed [63:0]   t;
    logic signed [63:0]   t2;
    logic signed [63:0]   acc;
    logic [63:0]          m;
    for (int k = 0; k <= QTR_N; k++) begin
      t   = 64'(k) << (16 - SINE_TABLE_BITS + 16);
      t2  = q30_mul(t, t);
      acc = CA9;
      acc = q30_mul(acc, t2) - CA7;
      acc = q30_mul(acc, t2) + CA5;
      acc = q30_mul(acc, t2) - CA3;
      acc = q30_mul(acc, t2) + CA1;
      acc = q30_mul(acc, t);
      if (acc < 0) acc = 0;
      if (acc > Q30_ONE) acc = Q30_ONE;
      if (half) begin
        m = (64'(acc) * 64'(FULL) + (64'd1 << 30)) >> 31;
      end else begin
        m = (64'(acc) * 64'(FULL) + (64'd1 << 29)) >> 30;
      end
      if (m > 64'(FULL)) m = 64'(FULL);
      tab[k] = m[SAMPLE_WIDTH-2:0];
    end
    return tab;
  endfunction

endpackage

>>> hdl/apsk16_sine.sv
`timescale 1ns / 1ps
// Phase-to-sample lookup: quarter-wave folding of a 16-bit phase and amplitude select.
// Depends on apsk16_pkg for the table builder and widths.
module apsk16_sine (
  input  logic [apsk16_pkg::PHASE_W-1:0] phase_i,
  input  logic                           half_i,
  output apsk16_pkg::sample_t            sample_o
);
  import apsk16_pkg::*;

  localparam mag_tab_t FULL_TAB = build_mag_tab(1'b0);
  localparam mag_tab_t HALF_TAB = build_mag_tab(1'b1);

  logic [SINE_TABLE_BITS-1:0] p;
  logic [1:0]                 quad;
  logic [POS_W-1:0]           r;
  logic [POS_W-1:0]           pos;
  mag_t                       mag;

  assign p    = phase_i[PHASE_W-1 -: SINE_TABLE_BITS];
  assign quad = p[SINE_TABLE_BITS-1 -: 2];
  assign r    = {1'b0, p[SINE_TABLE_BITS-3:0]};

  // Odd quadrants run the quarter wave backwards.
  assign pos = quad[0] ? (POS_W'(QTR_N) - r) : r;
  assign mag = half_i ? HALF_TAB[pos] : FULL_TAB[pos];

  assign sample_o = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

>>> hdl/sixteen_point_apsk_modulator.sv
`timescale 1ns / 1ps
// Throughput: one sample per cycle while sample_ready_i allows, from a phase accumulator
// and a combinational table lookup; bursts follow each other without a gap when the next
// symbol is already waiting. One completed symbol may wait behind a burst, after which
// input is held off once three more bits are collected.
// Reset (rst_ni low, asynchronous) empties all stages and restores the register defaults.
module sixteen_point_apsk_modulator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  apsk16_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [apsk16_pkg::MAP_W-1:0]     cfg_wdata_i,
  input  logic                             bit_valid_i,
  output logic                             bit_ready_o,
  input  logic                             bit_req_i,
  output logic                             sample_valid_o,
  input  logic                             sample_ready_i,
  output apsk16_pkg::sample_t              sample_o,
  output logic                             last_of_symbol_o
);
  import apsk16_pkg::*;

  logic [MAP_W-1:0]   map_q;
  logic [PHASE_W-1:0] step_q;
  logic [SPS_W-1:0]   sps_q;

  logic [1:0]         bits_q;
  logic [2:0]         part_q;

  logic               pend_vld_q;
  logic               pend_half_q;
  logic [2:0]         pend_oct_q;

  logic               gen_act_q;
  logic [PHASE_W-1:0] phase_q;
  logic               half_q;
  logic [CNT_W-1:0]   left_q;

  logic               out_vld_q;
  sample_t            out_smp_q;
  logic               out_last_q;

  logic               adv;
  logic               gen_fire;
  logic               gen_free;
  logic               pend_take;
  logic               bit_beat;
  logic [3:0]         sym;
  logic [3:0]         entry;
  logic [CNT_W-1:0]   count_eff;
  sample_t            sine_smp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= MAP_RESET;
      step_q <= STEP_RESET;
      sps_q  <= SPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYMBOL_MAP:         map_q  <= cfg_wdata_i;
        CFG_PHASE_STEP:         step_q <= cfg_wdata_i[PHASE_W-1:0];
        CFG_SAMPLES_PER_SYMBOL: sps_q  <= cfg_wdata_i[SPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_vld_q || sample_ready_i;
  assign gen_fire  = gen_act_q && adv;
  assign gen_free  = !gen_act_q || (gen_fire && (left_q == CNT_W'(1)));
  assign pend_take = pend_vld_q && gen_free;

  assign bit_ready_o = !((bits_q == 2'd3) && pend_vld_q);
  assign bit_beat    = bit_valid_i && bit_ready_o;
  assign sym         = {part_q, bit_req_i};
  assign entry       = map_q[{sym, 2'b00} +: 4];

  always_comb begin
    if (sps_q == '0) begin
      count_eff = CNT_W'(1);
    end else if (sps_q > SPS_W'(MAX_BURST)) begin
      count_eff = CNT_W'(MAX_BURST);
    end else begin
      count_eff = CNT_W'(sps_q);
    end
  end

  // Bit collector and the one-symbol holding slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q     <= '0;
      part_q     <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      if (bit_beat) begin
        bits_q <= bits_q + 2'd1;
        part_q <= (bits_q == 2'd3) ? 3'd0 : {part_q[1:0], bit_req_i};
      end
      if (bit_beat && (bits_q == 2'd3)) begin
        pend_vld_q <= 1'b1;
      end else if (pend_take) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bit_beat && (bits_q == 2'd3)) begin
      pend_half_q <= entry[3];
      pend_oct_q  <= entry[2:0];
    end
  end

  // Burst generator: phase restarts at the symbol's octant for every burst.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_act_q <= 1'b0;
      phase_q   <= '0;
      half_q    <= 1'b0;
      left_q    <= '0;
    end else if (pend_take) begin
      gen_act_q <= 1'b1;
      phase_q   <= {pend_oct_q, {(PHASE_W-3){1'b0}}};
      half_q    <= pend_half_q;
      left_q    <= count_eff;
    end else if (gen_fire) begin
      gen_act_q <= (left_q != CNT_W'(1));
      phase_q   <= phase_q + step_q;
      left_q    <= left_q - CNT_W'(1);
    end
  end

  apsk16_sine u_sine (
    .phase_i  (phase_q),
    .half_i   (half_q),
    .sample_o (sine_smp)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= gen_act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_fire) begin
      out_smp_q  <= sine_smp;
      out_last_q <= (left_q == CNT_W'(1));
    end
  end

  assign sample_valid_o   = out_vld_q;
  assign sample_o         = out_smp_q;
  assign last_of_symbol_o = out_last_q;

endmodule

>>> hdl/apsk16_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the 16-point APSK modulator, bound to the top level.
// Depends on apsk16_pkg and sixteen_point_apsk_modulator.
module apsk16_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sample_valid_o,
  input  logic                sample_ready_i,
  input  apsk16_pkg::sample_t sample_o,
  input  logic                last_of_symbol_o
);
  import apsk16_pkg::*;

  // A stalled output beat keeps its valid.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o && !sample_ready_i |=> sample_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled output beat keeps its payload.
  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o && !sample_ready_i |=> $stable(sample_o) && $stable(last_of_symbol_o))
    else $error("output payload changed while stalled");

  // Samples are symmetric: the most negative code is never produced.
  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> sample_o != SAMPLE_MIN)
    else $error("sample outside the symmetric range");

  // Reset never shows an output beat; the very first edge may still see an
  // uninitialised valid before the reset has taken hold.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> sample_valid_o !== 1'b1)
    else $error("output valid during reset");

endmodule

bind sixteen_point_apsk_modulator apsk16_checker u_apsk16_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .sample_valid_o   (sample_valid_o),
  .sample_ready_i   (sample_ready_i),
  .sample_o         (sample_o),
  .last_of_symbol_o (last_of_symbol_o)
);
